FILE: rtl/lrss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrss_pkg: shared types and constants of the lane row scan steering block
// Field widths, reset values, register indexes and the structs that travel
// between the front, the queue, the back end and the divider.
// ----------------------------------------------------------------------------
package lrss_pkg;

  localparam int PIX_W   = 8;
  localparam int COL_W   = 11;
  localparam int CFG_W   = 11;
  localparam int IDX_W   = 3;
  localparam int SUM_W   = 22;
  localparam int CNT_W   = 12;
  localparam int SERVO_W = 9;

  // Mapping arithmetic: span and divisor are signed, the numerator is the sum
  // of two products of a 10-bit signed servo value and a 24-bit signed term.
  localparam int SPAN_W = 12;
  localparam int OM_W   = 10;
  localparam int DEN_W  = 24;
  localparam int PROD_W = 34;
  localparam int NUM_W  = 36;

  localparam int MAX_COLS_DEF  = 2048;
  localparam int SERVO_MIN_DEF = 220;
  localparam int SERVO_MAX_DEF = 380;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [PIX_W-1:0]   EDGE_VALUE       = 8'd255;
  localparam int                 NEAR_LIMIT       = 15;
  localparam logic [SERVO_W-1:0] LAST_SERVO_RESET = 9'd300;

  localparam logic [CFG_W-1:0] SCAN_ROW_RESET    = 11'd560;
  localparam logic [CFG_W-1:0] LEFT_START_RESET  = 11'd72;
  localparam logic [CFG_W-1:0] LEFT_MEAN_RESET   = 11'd172;
  localparam logic [CFG_W-1:0] LEFT_STOP_RESET   = 11'd452;
  localparam logic [CFG_W-1:0] RIGHT_START_RESET = 11'd820;
  localparam logic [CFG_W-1:0] RIGHT_MEAN_RESET  = 11'd1100;
  localparam logic [CFG_W-1:0] RIGHT_STOP_RESET  = 11'd1200;

  typedef enum logic [IDX_W-1:0] {
    REG_SCAN_ROW    = 3'd0,
    REG_LEFT_START  = 3'd1,
    REG_LEFT_MEAN   = 3'd2,
    REG_LEFT_STOP   = 3'd3,
    REG_RIGHT_START = 3'd4,
    REG_RIGHT_MEAN  = 3'd5,
    REG_RIGHT_STOP  = 3'd6
  } reg_index_t;

  typedef struct packed {
    logic [CFG_W-1:0] scan_row;
    logic [CFG_W-1:0] left_start;
    logic [CFG_W-1:0] left_mean;
    logic [CFG_W-1:0] left_stop;
    logic [CFG_W-1:0] right_start;
    logic [CFG_W-1:0] right_mean;
    logic [CFG_W-1:0] right_stop;
  } cfg_t;

  // Accumulator snapshot of one finished frame.
  typedef struct packed {
    logic [SUM_W-1:0] left_sum;
    logic [CNT_W-1:0] left_count;
    logic [SUM_W-1:0] right_sum;
    logic [CNT_W-1:0] right_count;
  } snap_t;

  typedef struct packed {
    logic                    start;
    logic signed [NUM_W-1:0] num;
    logic signed [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [NUM_W-1:0] quo;
  } div_rsp_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_PROD,
    B_SEL,
    B_MUL1,
    B_MUL2,
    B_MUL3,
    B_SUM,
    B_DIV,
    B_NEXT,
    B_CHOOSE,
    B_OUT
  } back_state_t;

endpackage

FILE: rtl/lrss_pixel_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrss_pixel_if: pixel stream channel
// One edge-image pixel per transaction with its column, row and frame-end mark.
// ----------------------------------------------------------------------------
interface lrss_pixel_if;
  logic                      valid;
  logic                      ready;
  logic [lrss_pkg::PIX_W-1:0] pixel_value;
  logic [lrss_pkg::COL_W-1:0] column;
  logic [lrss_pkg::COL_W-1:0] row_index;
  logic                      frame_end;

  modport source (output valid, pixel_value, column, row_index, frame_end, input ready);
  modport sink   (input valid, pixel_value, column, row_index, frame_end, output ready);
endinterface

FILE: rtl/lrss_steer_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrss_steer_if: steering result channel
// One servo command per transaction, with the flag that tells a fresh value.
// ----------------------------------------------------------------------------
interface lrss_steer_if;
  logic                        valid;
  logic                        ready;
  logic [lrss_pkg::SERVO_W-1:0] servo_command;
  logic                        lane_seen;

  modport source (output valid, servo_command, lane_seen, input ready);
  modport sink   (input valid, servo_command, lane_seen, output ready);
endinterface

FILE: rtl/lrss_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrss_front: scan row accumulator
// Sums and counts edge columns in both windows and hands a snapshot of the
// accumulators to the queue on the last pixel of each frame.
// ----------------------------------------------------------------------------
module lrss_front #(
  parameter int MAX_COLS = lrss_pkg::MAX_COLS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  lrss_pixel_if.sink          pixel,
  input  lrss_pkg::cfg_t      cfg,
  input  logic                full,
  output logic                push,
  output lrss_pkg::snap_t     push_data
);

  localparam int COL_W = lrss_pkg::COL_W;
  localparam int SUM_W = lrss_pkg::SUM_W;
  localparam int CNT_W = lrss_pkg::CNT_W;
  localparam bit ALL_COLS = MAX_COLS >= (1 << COL_W);
  localparam logic [COL_W-1:0] COL_LIMIT = COL_W'(MAX_COLS);

  logic [SUM_W-1:0] left_sum, left_sum_next, right_sum, right_sum_next;
  logic [CNT_W-1:0] left_count, left_count_next, right_count, right_count_next;
  logic             accept, edge_hit, in_left, in_right;

  function automatic logic in_window(input logic [COL_W-1:0] col,
                                     input logic [COL_W-1:0] lo,
                                     input logic [COL_W-1:0] hi);
    logic [COL_W:0] hi_ext;
    hi_ext = {1'b0, hi} + (COL_W + 1)'(2);
    return (col >= lo) && ({1'b0, col} <= hi_ext);
  endfunction

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] sum,
                                               input logic [COL_W-1:0] col);
    logic [SUM_W:0] total;
    total = {1'b0, sum} + (SUM_W + 1)'(col);
    return total[SUM_W] ? '1 : total[SUM_W-1:0];
  endfunction

  assign pixel.ready = !full;
  assign accept      = pixel.valid && !full;

  assign edge_hit = (pixel.pixel_value == lrss_pkg::EDGE_VALUE) &&
                    (pixel.row_index == cfg.scan_row) &&
                    (ALL_COLS || (pixel.column < COL_LIMIT));
  assign in_left  = in_window(pixel.column, cfg.left_start, cfg.left_stop);
  assign in_right = in_window(pixel.column, cfg.right_start, cfg.right_stop);

  always_comb begin
    left_sum_next    = left_sum;
    left_count_next  = left_count;
    right_sum_next   = right_sum;
    right_count_next = right_count;
    if (edge_hit && in_left) begin
      left_sum_next   = sat_add(left_sum, pixel.column);
      left_count_next = (&left_count) ? left_count : left_count + CNT_W'(1);
    end
    if (edge_hit && in_right) begin
      right_sum_next   = sat_add(right_sum, pixel.column);
      right_count_next = (&right_count) ? right_count : right_count + CNT_W'(1);
    end
  end

  // The frame's last pixel is counted before the snapshot is taken.
  assign push                  = accept && pixel.frame_end;
  assign push_data.left_sum    = left_sum_next;
  assign push_data.left_count  = left_count_next;
  assign push_data.right_sum   = right_sum_next;
  assign push_data.right_count = right_count_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      left_sum    <= '0;
      left_count  <= '0;
      right_sum   <= '0;
      right_count <= '0;
    end else if (accept) begin
      if (pixel.frame_end) begin
        left_sum    <= '0;
        left_count  <= '0;
        right_sum   <= '0;
        right_count <= '0;
      end else begin
        left_sum    <= left_sum_next;
        left_count  <= left_count_next;
        right_sum   <= right_sum_next;
        right_count <= right_count_next;
      end
    end
  end

  a_clear_after_frame: assert property (@(posedge clk) disable iff (rst)
    push |=> (left_count == '0) && (right_count == '0) &&
             (left_sum == '0) && (right_sum == '0))
    else $error("accumulators not cleared after frame end");

endmodule

FILE: rtl/lrss_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrss_fifo: frame snapshot queue
// Small register queue that decouples the pixel accumulator from the mapping
// back end.
// ----------------------------------------------------------------------------
module lrss_fifo #(
  parameter int DEPTH = lrss_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  lrss_pkg::snap_t wdata,
  input  logic            pop,
  output lrss_pkg::snap_t rdata,
  output logic            full,
  output logic            empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  lrss_pkg::snap_t  mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("snapshot pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("snapshot popped from an empty queue");

endmodule

FILE: rtl/lrss_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrss_div: serial signed divider
// Restoring division on magnitudes, one quotient bit per cycle; the quotient
// is truncated toward zero.
// ----------------------------------------------------------------------------
module lrss_div (
  input  logic               clk,
  input  logic               rst,
  input  lrss_pkg::div_req_t req,
  output lrss_pkg::div_rsp_t rsp
);

  localparam int NUM_W  = lrss_pkg::NUM_W;
  localparam int DEN_W  = lrss_pkg::DEN_W;
  localparam int STEP_W = $clog2(NUM_W + 1);

  logic              busy, done;
  logic [STEP_W-1:0] steps;
  logic [NUM_W-1:0]  acc;
  logic [DEN_W-1:0]  rem, dmag;
  logic              neg;
  logic [DEN_W:0]    rem_sh, rem_sub;
  logic              q_bit;

  assign rem_sh  = {rem, acc[NUM_W-1]};
  assign rem_sub = rem_sh - {1'b0, dmag};
  assign q_bit   = (rem_sh >= {1'b0, dmag});

  assign rsp.done = done;
  assign rsp.quo  = neg ? -$signed(acc) : $signed(acc);

  always_ff @(posedge clk) begin
    if (req.start) begin
      acc  <= req.num[NUM_W-1] ? NUM_W'(-req.num) : req.num;
      dmag <= req.den[DEN_W-1] ? DEN_W'(-req.den) : req.den;
      rem  <= '0;
      neg  <= req.num[NUM_W-1] ^ req.den[DEN_W-1];
    end else if (busy) begin
      rem <= q_bit ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      acc <= {acc[NUM_W-2:0], q_bit};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(NUM_W);
      end else if (busy) begin
        steps <= steps - STEP_W'(1);
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: rtl/lrss_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrss_back: frame steering back end
// Maps each window's mean column onto the servo range, applies the closeness
// and side rule, clamps, and holds the result for the output channel.
// ----------------------------------------------------------------------------
module lrss_back #(
  parameter int SERVO_MIN = lrss_pkg::SERVO_MIN_DEF,
  parameter int SERVO_MAX = lrss_pkg::SERVO_MAX_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  lrss_pkg::cfg_t     cfg,
  input  logic               fifo_empty,
  input  lrss_pkg::snap_t    fifo_data,
  output logic               fifo_pop,
  output lrss_pkg::div_req_t div_req,
  input  lrss_pkg::div_rsp_t div_rsp,
  lrss_steer_if.source       steer
);

  localparam int COL_W   = lrss_pkg::COL_W;
  localparam int SUM_W   = lrss_pkg::SUM_W;
  localparam int CNT_W   = lrss_pkg::CNT_W;
  localparam int SPAN_W  = lrss_pkg::SPAN_W;
  localparam int OM_W    = lrss_pkg::OM_W;
  localparam int DEN_W   = lrss_pkg::DEN_W;
  localparam int PROD_W  = lrss_pkg::PROD_W;
  localparam int NUM_W   = lrss_pkg::NUM_W;
  localparam int SERVO_W = lrss_pkg::SERVO_W;
  localparam int MC_W    = COL_W + CNT_W;

  localparam int CENTER = SERVO_MIN + (SERVO_MAX - SERVO_MIN) / 2;
  localparam logic signed [OM_W-1:0]  OMIN_LO  = OM_W'(SERVO_MIN);
  localparam logic signed [OM_W-1:0]  OMIN_HI  = OM_W'(CENTER);
  localparam logic signed [OM_W-1:0]  DELTA_LO = OM_W'(CENTER - SERVO_MIN);
  localparam logic signed [OM_W-1:0]  DELTA_HI = OM_W'(SERVO_MAX - CENTER);
  localparam logic signed [NUM_W-1:0] CENTER_S = NUM_W'(CENTER);
  localparam logic signed [NUM_W-1:0] SMIN_S   = NUM_W'(SERVO_MIN);
  localparam logic signed [NUM_W-1:0] SMAX_S   = NUM_W'(SERVO_MAX);

  typedef enum logic [1:0] {
    VAL_ZERO,
    VAL_OMIN,
    VAL_QUO
  } val_src_t;

  lrss_pkg::back_state_t state, state_next;
  val_src_t              val_src;
  logic                  store_val, load_out;

  lrss_pkg::snap_t         work;
  logic                    side;
  logic [MC_W-1:0]         mc;
  logic [COL_W-1:0]        lo;
  logic signed [SPAN_W-1:0] span;
  logic signed [OM_W-1:0]  omin, odelta;
  logic signed [DEN_W-1:0] d;
  logic [MC_W-1:0]         lc;
  logic signed [DEN_W-1:0] n;
  logic signed [NUM_W-1:0] p1, p2;
  logic signed [NUM_W-1:0] lval, rval, sval, val_in;
  logic [SERVO_W-1:0]      last_servo;
  logic                    out_valid, out_seen;
  logic [SERVO_W-1:0]      out_servo;

  logic [SUM_W-1:0]         cur_sum;
  logic [CNT_W-1:0]         cur_cnt;
  logic [COL_W-1:0]         cur_start, cur_mean, cur_stop;
  logic signed [DEN_W:0]    d_full;
  logic signed [PROD_W-1:0] p1_full, p2_full;
  logic signed [NUM_W-1:0]  hold_val, clamp1, clamp2;
  logic                     hold, slot_free;

  function automatic logic signed [NUM_W-1:0] pick(input logic signed [NUM_W-1:0] a,
                                                   input logic signed [NUM_W-1:0] b);
    logic signed [NUM_W:0] s;
    s = {a[NUM_W-1], a} + {b[NUM_W-1], b};
    if (s[NUM_W]) begin
      s = s + (NUM_W + 1)'(1);
    end
    if (a != '0 && b != '0) begin
      return s[NUM_W:1];
    end else if (a != '0) begin
      return a;
    end else if (b != '0) begin
      return b;
    end
    return '1;
  endfunction

  function automatic logic signed [NUM_W-1:0] choose(input logic signed [NUM_W-1:0] l,
                                                     input logic signed [NUM_W-1:0] r);
    logic signed [NUM_W:0] diff;
    logic [NUM_W:0]        adiff;
    diff  = {r[NUM_W-1], r} - {l[NUM_W-1], l};
    adiff = diff[NUM_W] ? (NUM_W + 1)'(-diff) : (NUM_W + 1)'(diff);
    if (l == '0 || r == '0) begin
      return pick(l, r);
    end else if (adiff < (NUM_W + 1)'(lrss_pkg::NEAR_LIMIT)) begin
      return pick(l, r);
    end else if (l < CENTER_S && r < CENTER_S) begin
      return (l < r) ? l : r;
    end else if (l > CENTER_S && r > CENTER_S) begin
      return (l > r) ? l : r;
    end
    return pick(l, r);
  endfunction

  // Window operands of the side now being mapped.
  assign cur_sum   = side ? work.right_sum   : work.left_sum;
  assign cur_cnt   = side ? work.right_count : work.left_count;
  assign cur_start = side ? cfg.right_start  : cfg.left_start;
  assign cur_mean  = side ? cfg.right_mean   : cfg.left_mean;
  assign cur_stop  = side ? cfg.right_stop   : cfg.left_stop;

  assign d_full  = $signed({1'b0, cur_cnt}) * span;
  assign p1_full = omin * d;
  assign p2_full = odelta * n;

  assign slot_free = !out_valid || steer.ready;

  always_comb begin
    state_next = state;
    case (state)
      lrss_pkg::B_IDLE:   if (!fifo_empty) state_next = lrss_pkg::B_PROD;
      lrss_pkg::B_PROD:   state_next = (cur_cnt == '0) ? lrss_pkg::B_NEXT : lrss_pkg::B_SEL;
      lrss_pkg::B_SEL:    state_next = lrss_pkg::B_MUL1;
      lrss_pkg::B_MUL1:   state_next = lrss_pkg::B_MUL2;
      lrss_pkg::B_MUL2:   state_next = (d == '0) ? lrss_pkg::B_NEXT : lrss_pkg::B_MUL3;
      lrss_pkg::B_MUL3:   state_next = lrss_pkg::B_SUM;
      lrss_pkg::B_SUM:    state_next = lrss_pkg::B_DIV;
      lrss_pkg::B_DIV:    if (div_rsp.done) state_next = lrss_pkg::B_NEXT;
      lrss_pkg::B_NEXT:   state_next = side ? lrss_pkg::B_CHOOSE : lrss_pkg::B_PROD;
      lrss_pkg::B_CHOOSE: state_next = lrss_pkg::B_OUT;
      lrss_pkg::B_OUT:    if (slot_free) state_next = lrss_pkg::B_IDLE;
      default:            state_next = lrss_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    fifo_pop      = 1'b0;
    store_val     = 1'b0;
    val_src       = VAL_QUO;
    load_out      = 1'b0;
    div_req.start = 1'b0;
    div_req.num   = p1 + p2;
    div_req.den   = d;
    case (state)
      lrss_pkg::B_IDLE: fifo_pop = !fifo_empty;
      lrss_pkg::B_PROD: begin
        store_val = (cur_cnt == '0);
        val_src   = VAL_ZERO;
      end
      lrss_pkg::B_MUL2: begin
        store_val = (d == '0);
        val_src   = VAL_OMIN;
      end
      lrss_pkg::B_SUM:  div_req.start = 1'b1;
      lrss_pkg::B_DIV:  store_val = div_rsp.done;
      lrss_pkg::B_OUT:  load_out = slot_free;
      default: begin
      end
    endcase
  end

  always_comb begin
    case (val_src)
      VAL_ZERO: val_in = '0;
      VAL_OMIN: val_in = NUM_W'(omin);
      VAL_QUO:  val_in = div_rsp.quo;
      default:  val_in = '0;
    endcase
  end

  // Hold the last command when no window gave a value, then clamp.
  assign hold     = (sval == '1);
  assign hold_val = hold ? NUM_W'(last_servo) : sval;
  assign clamp1   = (hold_val <= SMIN_S) ? SMIN_S : hold_val;
  assign clamp2   = (clamp1 >= SMAX_S) ? SMAX_S : clamp1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lrss_pkg::B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side <= 1'b0;
    end else if (fifo_pop) begin
      side <= 1'b0;
    end else if (state == lrss_pkg::B_NEXT) begin
      side <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (fifo_pop) begin
      work <= fifo_data;
    end
    case (state)
      lrss_pkg::B_PROD: mc <= cur_mean * cur_cnt;
      lrss_pkg::B_SEL: begin
        if ({1'b0, cur_sum} < mc) begin
          lo     <= cur_start;
          span   <= $signed({1'b0, cur_mean}) - $signed({1'b0, cur_start});
          omin   <= OMIN_LO;
          odelta <= DELTA_LO;
        end else begin
          lo     <= cur_mean;
          span   <= $signed({1'b0, cur_stop}) - $signed({1'b0, cur_mean});
          omin   <= OMIN_HI;
          odelta <= DELTA_HI;
        end
      end
      lrss_pkg::B_MUL1: begin
        d  <= d_full[DEN_W-1:0];
        lc <= lo * cur_cnt;
      end
      lrss_pkg::B_MUL2: begin
        n  <= $signed({2'b00, cur_sum}) - $signed({1'b0, lc});
        p1 <= NUM_W'(p1_full);
      end
      lrss_pkg::B_MUL3:   p2 <= NUM_W'(p2_full);
      lrss_pkg::B_CHOOSE: sval <= choose(lval, rval);
      default: begin
      end
    endcase
    if (store_val) begin
      if (side) begin
        rval <= val_in;
      end else begin
        lval <= val_in;
      end
    end
    if (load_out) begin
      out_servo <= clamp2[SERVO_W-1:0];
      out_seen  <= !hold;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_servo <= lrss_pkg::LAST_SERVO_RESET;
      out_valid  <= 1'b0;
    end else begin
      if (load_out) begin
        last_servo <= clamp2[SERVO_W-1:0];
        out_valid  <= 1'b1;
      end else if (steer.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign steer.valid         = out_valid;
  assign steer.servo_command = out_servo;
  assign steer.lane_seen     = out_seen;

  a_div_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == lrss_pkg::B_DIV))
    else $error("divider finished outside its wait state");

  a_servo_in_range: assert property (@(posedge clk) disable iff (rst)
    steer.valid |-> (SERVO_MIN > SERVO_MAX) ||
                    ((int'(steer.servo_command) >= SERVO_MIN) &&
                     (int'(steer.servo_command) <= SERVO_MAX)))
    else $error("servo command outside the clamp range");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (rst)
    fifo_pop |=> (state == lrss_pkg::B_PROD) && !side)
    else $error("snapshot taken without starting on the left window");

endmodule

FILE: rtl/lane_row_scan_steering.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lane_row_scan_steering: lane-keeping steering from an edge-image stream
// Accumulates lane edge columns on one scan row and turns them into one
// clamped servo command per frame.
// ----------------------------------------------------------------------------
// The pixel channel takes one pixel per clock as long as the two-entry frame
// queue has room, so a camera stream at one pixel per cycle runs without
// stalls. On the pixel marked frame_end the left and right window sums and
// counts, that pixel included, are queued and the accumulators restart at
// zero. The back end then produces the result transaction: each window with
// edges is mapped through the multiply steps and, for a nonzero span, the
// shared one-bit-per-cycle divider that forms the exact mapped mean; then the
// side rule and the clamp are applied. The pixel side stalls only when two
// further frames end before the back end has finished and its result has
// been taken. lane_seen is low when neither window gave a usable value and
// the previous command is repeated. Configuration registers are written
// through cfg_write/cfg_index/cfg_data while no frame is in flight; an index
// beyond the last register is ignored.
// ----------------------------------------------------------------------------
module lane_row_scan_steering #(
  parameter int MAX_COLS  = lrss_pkg::MAX_COLS_DEF,
  parameter int SERVO_MIN = lrss_pkg::SERVO_MIN_DEF,
  parameter int SERVO_MAX = lrss_pkg::SERVO_MAX_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  lrss_pixel_if.sink                 pixel,
  lrss_steer_if.source               steer,
  input  logic                       cfg_write,
  input  logic [lrss_pkg::IDX_W-1:0] cfg_index,
  input  logic [lrss_pkg::CFG_W-1:0] cfg_data
);

  lrss_pkg::cfg_t     cfg;
  lrss_pkg::snap_t    push_data, pop_data;
  logic               push, pop, full, empty;
  lrss_pkg::div_req_t div_req;
  lrss_pkg::div_rsp_t div_rsp;

  // Configuration registers. The back end reads them live; the user must change
  // them only while no frame is being processed; the block does not enforce it.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.scan_row    <= lrss_pkg::SCAN_ROW_RESET;
      cfg.left_start  <= lrss_pkg::LEFT_START_RESET;
      cfg.left_mean   <= lrss_pkg::LEFT_MEAN_RESET;
      cfg.left_stop   <= lrss_pkg::LEFT_STOP_RESET;
      cfg.right_start <= lrss_pkg::RIGHT_START_RESET;
      cfg.right_mean  <= lrss_pkg::RIGHT_MEAN_RESET;
      cfg.right_stop  <= lrss_pkg::RIGHT_STOP_RESET;
    end else if (cfg_write) begin
      case (lrss_pkg::reg_index_t'(cfg_index))
        lrss_pkg::REG_SCAN_ROW:    cfg.scan_row    <= cfg_data;
        lrss_pkg::REG_LEFT_START:  cfg.left_start  <= cfg_data;
        lrss_pkg::REG_LEFT_MEAN:   cfg.left_mean   <= cfg_data;
        lrss_pkg::REG_LEFT_STOP:   cfg.left_stop   <= cfg_data;
        lrss_pkg::REG_RIGHT_START: cfg.right_start <= cfg_data;
        lrss_pkg::REG_RIGHT_MEAN:  cfg.right_mean  <= cfg_data;
        lrss_pkg::REG_RIGHT_STOP:  cfg.right_stop  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Front: one pixel per cycle into the window accumulators while the queue has room.
  lrss_front #(
    .MAX_COLS (MAX_COLS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .pixel     (pixel),
    .cfg       (cfg),
    .full      (full),
    .push      (push),
    .push_data (push_data)
  );

  // Queue of finished frame snapshots between front and back.
  lrss_fifo #(
    .DEPTH (lrss_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (push_data),
    .pop   (pop),
    .rdata (pop_data),
    .full  (full),
    .empty (empty)
  );

  // Serial divider shared by the left and right mappings.
  lrss_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Back: mapping, side rule, clamp and the output register.
  lrss_back #(
    .SERVO_MIN (SERVO_MIN),
    .SERVO_MAX (SERVO_MAX)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .fifo_empty (empty),
    .fifo_data  (pop_data),
    .fifo_pop   (pop),
    .div_req    (div_req),
    .div_rsp    (div_rsp),
    .steer      (steer)
  );

endmodule

FILE: sim/tb_lane_row_scan_steering.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lane_row_scan_steering: self-checking bench of the lane row scan steering
// Feeds pixel frames through the pixel channel with random gaps and takes the
// steering results with random back-pressure. Every accepted pixel also goes
// into a cycle-free model of the window sums, the mean mapping, the side rule
// and the clamp, and each steering transaction is compared with that model.
// ----------------------------------------------------------------------------
module tb_lane_row_scan_steering;

  localparam int PIX_W   = lrss_pkg::PIX_W;
  localparam int COL_W   = lrss_pkg::COL_W;
  localparam int CFG_W   = lrss_pkg::CFG_W;
  localparam int IDX_W   = lrss_pkg::IDX_W;
  localparam int SUM_W   = lrss_pkg::SUM_W;
  localparam int CNT_W   = lrss_pkg::CNT_W;
  localparam int SERVO_W = lrss_pkg::SERVO_W;

  // Servo range and mapping center as the block is built by default.
  localparam longint SERVO_LO   = lrss_pkg::SERVO_MIN_DEF;
  localparam longint SERVO_HI   = lrss_pkg::SERVO_MAX_DEF;
  localparam longint SERVO_MID  = SERVO_LO + (SERVO_HI - SERVO_LO) / 2;
  localparam int     MAX_COLS   = lrss_pkg::MAX_COLS_DEF;
  localparam int unsigned SUM_CAP = (1 << SUM_W) - 1;
  localparam int unsigned CNT_CAP = (1 << CNT_W) - 1;

  // One past the last register; the block must drop writes to it.
  localparam logic [IDX_W-1:0] UNUSED_INDEX = 3'd7;

  // This settle time covers any work still in flight before the registers are touched.
  localparam int SETTLE_CYCLES = 150;
  localparam int HOLD_OFF_CYCLES = 600;
  localparam int BURST_FRAMES = 10;
  localparam int BURST_LEN = 3;
  localparam int LONG_FRAME_PIXELS = 40;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int NUM_PROBES = 20;

  typedef struct packed {
    logic [SERVO_W-1:0] servo_command;
    logic               lane_seen;
  } steer_t;

  // One row of the directed stimulus. Where typed is set, want holds the
  // result that follows directly from the reset settings.
  typedef struct packed {
    logic [PIX_W-1:0] pixel_value;
    logic [COL_W-1:0] column;
    logic [COL_W-1:0] row_index;
    logic             frame_end;
    bit               typed;
    steer_t           want;
  } probe_t;

  logic clk;
  logic rst;
  logic             cfg_write;
  logic [IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  lrss_pixel_if pixel_ch ();
  lrss_steer_if steer_ch ();

  lane_row_scan_steering dut (
    .clk       (clk),
    .rst       (rst),
    .pixel     (pixel_ch),
    .steer     (steer_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Model state: the register settings, the window accumulators of the frame
  // in progress and the last command sent.
  lrss_pkg::cfg_t     cfg_model;
  lrss_pkg::snap_t    acc;
  logic [SERVO_W-1:0] last_servo_model;

  steer_t expected_steer [$];

  int  errors = 0;
  int  pixels_sent = 0;
  int  results_checked = 0;
  int  held_expected = 0;
  int  settings_loaded = 0;
  int  cycle_count = 0;
  bit  steady_feed = 0;
  bit  squeeze = 0;

  // Directed rows, run under the reset settings. The first rows pin down the
  // window edges (start, stop plus 2, one column past each), the hold of the
  // reset command, non-edge values and wrong rows. The later rows build frames
  // that hit both windows: near each other, both left of center, both right of
  // center, opposite sides; the last row, at right stop plus 3, hits neither.
  probe_t probe_table [0:NUM_PROBES-1] = '{
    '{8'd0,   11'd0,    11'd0,    1'b1, 1'b1, '{9'd300, 1'b0}},
    '{8'd255, 11'd172,  11'd560,  1'b1, 1'b1, '{9'd300, 1'b1}},
    '{8'd255, 11'd72,   11'd560,  1'b1, 1'b1, '{9'd220, 1'b1}},
    '{8'd255, 11'd454,  11'd560,  1'b1, 1'b1, '{9'd380, 1'b1}},
    '{8'd255, 11'd455,  11'd560,  1'b1, 1'b1, '{9'd380, 1'b0}},
    '{8'd255, 11'd71,   11'd560,  1'b1, 1'b1, '{9'd380, 1'b0}},
    '{8'd254, 11'd172,  11'd560,  1'b1, 1'b1, '{9'd380, 1'b0}},
    '{8'd255, 11'd172,  11'd559,  1'b1, 1'b1, '{9'd380, 1'b0}},
    '{8'd255, 11'd1100, 11'd560,  1'b1, 1'b1, '{9'd300, 1'b1}},
    '{8'd255, 11'd2047, 11'd2047, 1'b0, 1'b0, '{9'd0,   1'b0}},
    '{8'd255, 11'd0,    11'd560,  1'b0, 1'b0, '{9'd0,   1'b0}},
    '{8'd255, 11'd172,  11'd560,  1'b0, 1'b0, '{9'd0,   1'b0}},
    '{8'd255, 11'd1100, 11'd560,  1'b1, 1'b1, '{9'd300, 1'b1}},
    '{8'd255, 11'd100,  11'd560,  1'b0, 1'b0, '{9'd0,   1'b0}},
    '{8'd255, 11'd820,  11'd560,  1'b1, 1'b0, '{9'd0,   1'b0}},
    '{8'd255, 11'd400,  11'd560,  1'b0, 1'b0, '{9'd0,   1'b0}},
    '{8'd255, 11'd1200, 11'd560,  1'b1, 1'b0, '{9'd0,   1'b0}},
    '{8'd255, 11'd100,  11'd560,  1'b0, 1'b0, '{9'd0,   1'b0}},
    '{8'd255, 11'd1202, 11'd560,  1'b1, 1'b0, '{9'd0,   1'b0}},
    '{8'd255, 11'd1203, 11'd560,  1'b1, 1'b0, '{9'd0,   1'b0}}
  };

  // --------------------------------------------------------------------------
  // Model of the block
  // --------------------------------------------------------------------------

  // Adds one edge column to a window if it lies in start..stop+2. Sum and
  // count stick at their all-ones values instead of wrapping.
  task automatic gather(input logic [COL_W-1:0] col, input logic [CFG_W-1:0] lo,
                        input logic [CFG_W-1:0] hi, inout logic [SUM_W-1:0] sum,
                        inout logic [CNT_W-1:0] cnt);
    int unsigned total;
    if (col < lo || int'(col) > int'(hi) + 2) return;
    total = 32'(sum) + 32'(col);
    sum = (total > SUM_CAP) ? SUM_CAP[SUM_W-1:0] : total[SUM_W-1:0];
    if (cnt != CNT_CAP[CNT_W-1:0]) cnt = cnt + 1'b1;
  endtask

  // Exact linear map of the mean sum/cnt from in_lo..in_hi onto omin..omax,
  // truncated toward zero only once. A zero divisor gives the low output.
  function automatic longint span_map(longint sum, longint cnt, longint in_lo,
                                      longint in_hi, longint omin, longint omax);
    longint den, num;
    den = cnt * (in_hi - in_lo);
    if (den == 0) return omin;
    num = omin * den + (omax - omin) * (sum - in_lo * cnt);
    return num / den;
  endfunction

  // Servo value of one window; zero stands for a window that saw no edges.
  function automatic longint window_servo(longint sum, longint cnt, longint lo,
                                          longint mean, longint hi);
    if (cnt == 0) return 0;
    if (sum < mean * cnt) return span_map(sum, cnt, lo, mean, SERVO_LO, SERVO_MID);
    return span_map(sum, cnt, mean, hi, SERVO_MID, SERVO_HI);
  endfunction

  function automatic longint both_or_one(longint a, longint b);
    if (a != 0 && b != 0) return (a + b) / 2;
    if (a != 0) return a;
    if (b != 0) return b;
    return -1;
  endfunction

  // Side rule: a lone value is kept, close values are averaged, two values on
  // the same side of center give the one farther out, other pairs are averaged.
  function automatic longint pick_side(longint l, longint r);
    longint diff;
    if (l == 0 || r == 0) return both_or_one(l, r);
    diff = (r > l) ? r - l : l - r;
    if (diff < lrss_pkg::NEAR_LIMIT) return both_or_one(l, r);
    if (l < SERVO_MID && r < SERVO_MID) return (l < r) ? l : r;
    if (l > SERVO_MID && r > SERVO_MID) return (l > r) ? l : r;
    return both_or_one(l, r);
  endfunction

  // Takes one accepted pixel into the model. On the frame end it forms the
  // steering result, updates the held command and clears the accumulators.
  task automatic absorb_pixel(input logic [PIX_W-1:0] pix, input logic [COL_W-1:0] col,
                              input logic [COL_W-1:0] row, input logic fend,
                              output bit made, output steer_t res);
    longint l, r, s;
    made = 0;
    res = '0;
    if (pix == lrss_pkg::EDGE_VALUE && row == cfg_model.scan_row &&
        int'(col) < MAX_COLS) begin
      gather(col, cfg_model.left_start, cfg_model.left_stop, acc.left_sum, acc.left_count);
      gather(col, cfg_model.right_start, cfg_model.right_stop, acc.right_sum,
             acc.right_count);
    end
    if (!fend) return;
    l = window_servo(longint'(acc.left_sum), longint'(acc.left_count),
                     longint'(cfg_model.left_start), longint'(cfg_model.left_mean),
                     longint'(cfg_model.left_stop));
    r = window_servo(longint'(acc.right_sum), longint'(acc.right_count),
                     longint'(cfg_model.right_start), longint'(cfg_model.right_mean),
                     longint'(cfg_model.right_stop));
    s = pick_side(l, r);
    res.lane_seen = (s != -1);
    if (!res.lane_seen) s = longint'(last_servo_model);
    if (s <= SERVO_LO) s = SERVO_LO;
    if (s >= SERVO_HI) s = SERVO_HI;
    last_servo_model = s[SERVO_W-1:0];
    res.servo_command = last_servo_model;
    acc = '0;
    made = 1;
  endtask

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // Offers one pixel after a random gap, waits for the transaction and hands
  // the pixel to the model. A typed result replaces the model's result as the
  // expectation, while the model still tracks its own state.
  task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic [COL_W-1:0] col,
                            input logic [COL_W-1:0] row, input logic fend,
                            input bit typed = 0, input steer_t typed_res = '0);
    int     gap;
    bit     made;
    steer_t res;
    gap = steady_feed ? 0 : $urandom_range(0, 17);
    @(negedge clk);
    if (gap > 0) begin
      pixel_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    pixel_ch.valid       = 1'b1;
    pixel_ch.pixel_value = pix;
    pixel_ch.column      = col;
    pixel_ch.row_index   = row;
    pixel_ch.frame_end   = fend;
    do @(posedge clk); while (!pixel_ch.ready);
    pixels_sent++;
    absorb_pixel(pix, col, row, fend, made, res);
    if (made) begin
      if (typed) res = typed_res;
      if (!res.lane_seen) held_expected++;
      expected_steer.insert(expected_steer.size(), res);
    end
  endtask

  // Register writes go out one at a time, with cfg_write low between them.
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_write = 1'b0;
    case (idx)
      lrss_pkg::REG_SCAN_ROW:    cfg_model.scan_row    = data;
      lrss_pkg::REG_LEFT_START:  cfg_model.left_start  = data;
      lrss_pkg::REG_LEFT_MEAN:   cfg_model.left_mean   = data;
      lrss_pkg::REG_LEFT_STOP:   cfg_model.left_stop   = data;
      lrss_pkg::REG_RIGHT_START: cfg_model.right_start = data;
      lrss_pkg::REG_RIGHT_MEAN:  cfg_model.right_mean  = data;
      lrss_pkg::REG_RIGHT_STOP:  cfg_model.right_stop  = data;
      default: ;
    endcase
  endtask

  task automatic load_settings(input lrss_pkg::cfg_t c);
    write_reg(lrss_pkg::REG_SCAN_ROW, c.scan_row);
    write_reg(lrss_pkg::REG_LEFT_START, c.left_start);
    write_reg(lrss_pkg::REG_LEFT_MEAN, c.left_mean);
    write_reg(lrss_pkg::REG_LEFT_STOP, c.left_stop);
    write_reg(lrss_pkg::REG_RIGHT_START, c.right_start);
    write_reg(lrss_pkg::REG_RIGHT_MEAN, c.right_mean);
    write_reg(lrss_pkg::REG_RIGHT_STOP, c.right_stop);
    settings_loaded++;
  endtask

  // Random window: mostly narrow or medium spans, sometimes reversed or with
  // a stop anywhere; the mean usually lies inside the span.
  task automatic draw_window(output logic [CFG_W-1:0] lo, output logic [CFG_W-1:0] mean,
                             output logic [CFG_W-1:0] hi);
    int kind, lo_i, hi_i, a, b;
    kind = $urandom_range(0, 9);
    lo_i = $urandom_range(0, 2047);
    if (kind < 4) hi_i = lo_i + $urandom_range(0, 8);
    else if (kind < 8) hi_i = lo_i + $urandom_range(0, 600);
    else if (kind == 8) hi_i = lo_i - $urandom_range(3, 200);
    else hi_i = $urandom_range(0, 2047);
    if (hi_i > 2047) hi_i = 2047;
    if (hi_i < 0) hi_i = 0;
    a = (lo_i < hi_i) ? lo_i : hi_i;
    b = (lo_i < hi_i) ? hi_i : lo_i;
    lo   = CFG_W'(lo_i);
    hi   = CFG_W'(hi_i);
    mean = ($urandom_range(0, 3) != 0) ? CFG_W'($urandom_range(b, a)) :
                                         CFG_W'($urandom_range(0, 2047));
  endtask

  // Pixels aim mostly at a window on the scan row, with a margin of a few
  // columns around it so that both edges of each window get hit.
  task automatic draw_pixel(input bit quiet, output logic [PIX_W-1:0] pix,
                            output logic [COL_W-1:0] col, output logic [COL_W-1:0] row);
    int pick, a, b;
    logic [CFG_W-1:0] lo, hi;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 1)) begin
      lo = cfg_model.left_start;
      hi = cfg_model.left_stop;
    end else begin
      lo = cfg_model.right_start;
      hi = cfg_model.right_stop;
    end
    a = (lo >= 3) ? int'(lo) - 3 : 0;
    b = (int'(hi) + 5 > 2047) ? 2047 : int'(hi) + 5;
    if (b < a) b = (a + 8 > 2047) ? 2047 : a + 8;
    pix = lrss_pkg::EDGE_VALUE;
    col = COL_W'($urandom_range(b, a));
    row = cfg_model.scan_row;
    if (pick >= 70 && pick < 80) begin
      col = COL_W'($urandom_range(0, 2047));
    end else if (pick >= 80 && pick < 90) begin
      pix = PIX_W'($urandom_range(0, 254));
    end else if (pick >= 90) begin
      pix = PIX_W'($urandom_range(0, 255));
      col = COL_W'($urandom_range(0, 2047));
      row = COL_W'($urandom_range(0, 2047));
    end
    if (quiet) pix = PIX_W'($urandom_range(0, 254));
  endtask

  // A frame is a short run of pixels closed by one marked frame_end. Some
  // frames come without gaps, and some carry no edge at all.
  task automatic send_frame();
    int extra;
    bit quiet;
    logic [PIX_W-1:0] pix;
    logic [COL_W-1:0] col, row;
    steady_feed = ($urandom_range(0, 3) == 0);
    quiet = ($urandom_range(0, 5) == 0);
    extra = $urandom_range(0, 20);
    for (int k = 0; k <= extra; k++) begin
      draw_pixel(quiet, pix, col, row);
      send_pixel(pix, col, row, k == extra);
    end
  endtask

  task automatic run_random(input int items);
    int target;
    target = pixels_sent + items;
    while (pixels_sent < target) send_frame();
  endtask

  // Waits until every expected result has been taken, then lets the back end
  // settle. Only after this are the registers written.
  task automatic drain();
    @(negedge clk);
    pixel_ch.valid = 1'b0;
    while (expected_steer.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Clock, reset and run limit
  // --------------------------------------------------------------------------

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // The run stops here if the block hangs or loses a result.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: run limit of %0d cycles reached, %0d results outstanding",
               $time, CYCLE_LIMIT, expected_steer.size());
      $display("[lane_row_scan_steering] ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Result side
  // --------------------------------------------------------------------------

  // The receiver draws a wait before every result. Stretches of 16 results
  // run without waits now and then. Once the stimulus asks for it, the
  // receiver holds ready low for a long stretch while the sender keeps
  // going, so that the frame queue fills up and the pixel channel has to stall.
  initial begin
    int  wait_cycles;
    int  results_taken;
    bit  steady_take;
    bit  held_off;
    results_taken = 0;
    steady_take = 0;
    held_off = 0;
    steer_ch.ready = 1'b0;
    forever begin
      wait_cycles = steady_take ? 0 : $urandom_range(0, 17);
      if (squeeze && !held_off) begin
        wait_cycles = HOLD_OFF_CYCLES;
        held_off = 1'b1;
      end
      @(negedge clk);
      if (wait_cycles > 0) begin
        steer_ch.ready = 1'b0;
        repeat (wait_cycles) @(negedge clk);
      end
      steer_ch.ready = 1'b1;
      do @(posedge clk); while (!(steer_ch.valid && !rst));
      results_taken++;
      if (results_taken % 16 == 0) steady_take = ($urandom_range(0, 2) == 0);
    end
  end

  // Every result transaction is compared with the oldest expectation.
  always @(posedge clk) begin
    steer_t want;
    if (!rst && steer_ch.valid && steer_ch.ready) begin
      results_checked++;
      if (expected_steer.size() == 0) begin
        $display("%0t: steering transaction with none expected: servo_command=%0d lane_seen=%0d",
                 $time, steer_ch.servo_command, steer_ch.lane_seen);
        errors++;
      end else begin
        want = expected_steer.pop_front();
        if (steer_ch.servo_command !== want.servo_command) begin
          $display("%0t: servo_command expected %0d, got %0d", $time,
                   want.servo_command, steer_ch.servo_command);
          errors++;
        end
        if (steer_ch.lane_seen !== want.lane_seen) begin
          $display("%0t: lane_seen expected %0d, got %0d", $time,
                   want.lane_seen, steer_ch.lane_seen);
          errors++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus sequence
  // --------------------------------------------------------------------------

  initial begin
    lrss_pkg::cfg_t   setting;
    logic [COL_W-1:0] long_row;
    logic [PIX_W-1:0] pix;
    logic [COL_W-1:0] col, row;

    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    pixel_ch.valid       = 1'b0;
    pixel_ch.pixel_value = '0;
    pixel_ch.column      = '0;
    pixel_ch.row_index   = '0;
    pixel_ch.frame_end   = 1'b0;

    cfg_model = '{lrss_pkg::SCAN_ROW_RESET, lrss_pkg::LEFT_START_RESET,
                  lrss_pkg::LEFT_MEAN_RESET, lrss_pkg::LEFT_STOP_RESET,
                  lrss_pkg::RIGHT_START_RESET, lrss_pkg::RIGHT_MEAN_RESET,
                  lrss_pkg::RIGHT_STOP_RESET};
    acc = '0;
    last_servo_model = lrss_pkg::LAST_SERVO_RESET;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed rows under the reset settings.
    foreach (probe_table[i])
      send_pixel(probe_table[i].pixel_value, probe_table[i].column,
                 probe_table[i].row_index, probe_table[i].frame_end,
                 probe_table[i].typed, probe_table[i].want);
    drain();

    // A burst of very short frames without gaps while the receiver holds
    // off: the back end falls behind, the frame queue fills and the pixel
    // channel stalls.
    squeeze = 1'b1;
    for (int f = 0; f < BURST_FRAMES; f++) begin
      for (int k = 0; k < BURST_LEN; k++) begin
        steady_feed = 1'b1;
        draw_pixel(1'b0, pix, col, row);
        send_pixel(pix, col, row, k == BURST_LEN - 1);
      end
    end
    steady_feed = 1'b0;
    drain();

    // A write to the unused index must leave every register as it was.
    write_reg(UNUSED_INDEX, 11'd0);
    run_random(60);
    drain();

    // All registers at zero: both windows cover columns 0..2 and every
    // mapping span is empty.
    load_settings('0);
    run_random(80);
    drain();

    // All registers at their top value: the scan row is the last one and the
    // windows reach past the last column.
    load_settings('1);
    run_random(80);
    drain();

    // A reversed left window that takes nothing, and a one-column right
    // window with its mean just outside.
    load_settings('{11'd1, 11'd1800, 11'd900, 11'd300, 11'd1000, 11'd1001, 11'd998});
    run_random(80);
    drain();

    // Random settings.
    repeat (6) begin
      setting.scan_row = CFG_W'($urandom_range(0, 2047));
      draw_window(setting.left_start, setting.left_mean, setting.left_stop);
      draw_window(setting.right_start, setting.right_mean, setting.right_stop);
      load_settings(setting);
      run_random(70);
      drain();
    end

    // One longer gap-free frame of edges in two overlapping windows, so that
    // many pixels count in both at once.
    long_row = COL_W'($urandom_range(0, 2047));
    load_settings('{long_row, 11'd0, 11'd1024, 11'd2047, 11'd1500, 11'd1600, 11'd2047});
    steady_feed = 1'b1;
    for (int k = 0; k < LONG_FRAME_PIXELS; k++)
      send_pixel(lrss_pkg::EDGE_VALUE, COL_W'($urandom_range(1500, 2047)), long_row,
                 k == LONG_FRAME_PIXELS - 1);
    drain();

    $display("Sent %0d pixel transactions under %0d register settings, among them all-zero,",
             pixels_sent, settings_loaded + 1);
    $display("all-ones, reversed, stalled-burst and overlapping cases; %0d results checked, %0d held.",
             results_checked, held_expected);
    if (errors == 0) begin
      $display("[lane_row_scan_steering] OK");
    end else begin
      $display("%0d mismatches found", errors);
      $display("[lane_row_scan_steering] ERROR");
    end
    $finish;
  end

endmodule
